/* src/rse_pkg.sv */
`default_nettype none

package rse_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned MODE_W      = 4;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned DEPTH_W     = 5;

  // literal, line_start
  localparam int unsigned IN_FIELDS_W  = DATA_W + 1;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  // printed_valid, printed_value, show_stack, stack_depth, three stack words
  localparam int unsigned OUT_FIELDS_W = 1 + DATA_W + 1 + DEPTH_W + 3 * DATA_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [PTR_W-1:0]  ptr_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 4'd0,
    MODE_ADD   = 4'd1,
    MODE_SUB   = 4'd2,
    MODE_MUL   = 4'd3,
    MODE_DIV   = 4'd4,
    MODE_MOD   = 4'd5,
    MODE_DUP   = 4'd6,
    MODE_DROP  = 4'd7,
    MODE_SWAP  = 4'd8,
    MODE_OVER  = 4'd9,
    MODE_PRINT = 4'd10,
    MODE_SHOW  = 4'd11,
    MODE_CLEAR = 4'd12
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_DIV0  = 3'd1,
    ST_OVER  = 3'd2,
    ST_UNDER = 3'd3,
    ST_SKIP  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP,
    OP_FILL,
    OP_SWAP,
    OP_SETTOP,
    OP_CLEAR
  } dp_op_e;

  typedef enum logic [1:0] {
    PSEL_LIT,
    PSEL_TOP,
    PSEL_SEC
  } push_sel_e;

  typedef enum logic [1:0] {
    MD_MUL,
    MD_DIV,
    MD_MOD
  } md_op_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EXEC,
    CS_POP,
    CS_FILL,
    CS_MDWAIT,
    CS_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic      load_in;
    dp_op_e    op;
    push_sel_e psel;
    logic      latch_ops;
    logic      md_start;
    md_op_e    md_op;
    logic      cap_print;
    logic      set_show;
    logic      wr_out;
    status_e   status;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  skip;
    logic  cnt_zero;
    logic  cnt_lt2;
    logic  cnt_full;
    logic  b_zero;
    logic  md_busy;
    logic  out_busy;
  } sts_t;

endpackage

`default_nettype wire

/* src/rse_muldiv.sv */
`default_nettype none

module rse_muldiv (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire rse_pkg::md_op_e op_i,
  input  wire rse_pkg::word_t a_i,
  input  wire rse_pkg::word_t b_i,
  output logic                busy_o,
  output rse_pkg::word_t      result_o
);
  import rse_pkg::*;

  localparam int unsigned STEP_W = $clog2(DATA_W);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  md_op_e            op_q;
  logic              neg_q;
  word_t             acc_q;  // product or partial remainder
  word_t             x_q;    // multiplicand or dividend/quotient shifter
  word_t             y_q;    // multiplier or divisor magnitude

  word_t             mag_a;
  word_t             mag_b;
  logic [DATA_W+1:0] trial;

  always_comb begin
    mag_a = a_i[DATA_W-1] ? (word_t'(0) - a_i) : a_i;
    mag_b = b_i[DATA_W-1] ? (word_t'(0) - b_i) : b_i;
    trial = {1'b0, acc_q, x_q[DATA_W-1]} - {2'b00, y_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(DATA_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q  <= op_i;
      acc_q <= '0;
      if (op_i == MD_MUL) begin
        x_q   <= a_i;
        y_q   <= b_i;
        neg_q <= 1'b0;
      end else begin
        x_q   <= mag_a;
        y_q   <= mag_b;
        neg_q <= (op_i == MD_DIV) ? (a_i[DATA_W-1] ^ b_i[DATA_W-1]) : a_i[DATA_W-1];
      end
    end else if (busy_q) begin
      if (op_q == MD_MUL) begin
        if (y_q[0]) begin
          acc_q <= acc_q + x_q;
        end
        x_q <= {x_q[DATA_W-2:0], 1'b0};
        y_q <= {1'b0, y_q[DATA_W-1:1]};
      end else if (!trial[DATA_W+1]) begin
        acc_q <= trial[DATA_W-1:0];
        x_q   <= {x_q[DATA_W-2:0], 1'b1};
      end else begin
        acc_q <= {acc_q[DATA_W-2:0], x_q[DATA_W-1]};
        x_q   <= {x_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    busy_o = busy_q;
    case (op_q)
      MD_MUL:  result_o = acc_q;
      MD_DIV:  result_o = neg_q ? (word_t'(0) - x_q) : x_q;
      default: result_o = neg_q ? (word_t'(0) - acc_q) : acc_q;
    endcase
  end

endmodule

`default_nettype wire

/* src/rse_ctrl.sv */
`default_nettype none

module rse_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  input  wire rse_pkg::sts_t sts_i,
  output rse_pkg::cmd_t      cmd_o
);
  import rse_pkg::*;

  ctrl_state_e state_q, state_d;
  status_e     status_q, status_d;
  logic        second_pop_q, second_pop_d;
  logic        settop_q, settop_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= CS_IDLE;
      status_q     <= ST_OK;
      second_pop_q <= 1'b0;
      settop_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      status_q     <= status_d;
      second_pop_q <= second_pop_d;
      settop_q     <= settop_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    status_d     = status_q;
    second_pop_d = second_pop_q;
    settop_d     = settop_q;
    cmd_o        = '0;
    cmd_o.status = status_q;
    s_tready_o   = (state_q == CS_IDLE);

    unique case (state_q)
      CS_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = CS_EXEC;
        end
      end

      CS_EXEC: begin
        status_d     = ST_OK;
        second_pop_d = 1'b0;
        settop_d     = 1'b0;
        state_d      = CS_DONE;
        if (sts_i.skip) begin
          status_d = ST_SKIP;
        end else begin
          unique case (sts_i.mode) inside
            MODE_PUSH: begin
              if (sts_i.cnt_full) begin
                status_d = ST_OVER;
              end else begin
                cmd_o.op   = OP_PUSH;
                cmd_o.psel = PSEL_LIT;
              end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD: begin
              if (sts_i.cnt_zero) begin
                status_d = ST_UNDER;
              end else if (sts_i.cnt_lt2) begin
                // single operand is still popped
                cmd_o.op = OP_POP;
                status_d = ST_UNDER;
                state_d  = CS_FILL;
              end else begin
                cmd_o.op        = OP_POP;
                cmd_o.latch_ops = 1'b1;
                state_d         = CS_FILL;
                if ((sts_i.mode == MODE_DIV || sts_i.mode == MODE_MOD) && sts_i.b_zero) begin
                  status_d     = ST_DIV0;
                  second_pop_d = 1'b1;
                end else begin
                  settop_d = 1'b1;
                  if (sts_i.mode == MODE_MUL) begin
                    cmd_o.md_start = 1'b1;
                    cmd_o.md_op    = MD_MUL;
                  end else if (sts_i.mode == MODE_DIV) begin
                    cmd_o.md_start = 1'b1;
                    cmd_o.md_op    = MD_DIV;
                  end else if (sts_i.mode == MODE_MOD) begin
                    cmd_o.md_start = 1'b1;
                    cmd_o.md_op    = MD_MOD;
                  end
                end
              end
            end
            MODE_DUP: begin
              if (sts_i.cnt_zero) begin
                status_d = ST_UNDER;
              end else if (sts_i.cnt_full) begin
                status_d = ST_OVER;
              end else begin
                cmd_o.op   = OP_PUSH;
                cmd_o.psel = PSEL_TOP;
              end
            end
            MODE_DROP: begin
              if (sts_i.cnt_zero) begin
                status_d = ST_UNDER;
              end else begin
                cmd_o.op = OP_POP;
                state_d  = CS_FILL;
              end
            end
            MODE_SWAP: begin
              if (sts_i.cnt_lt2) begin
                status_d = ST_UNDER;
              end else begin
                cmd_o.op = OP_SWAP;
              end
            end
            MODE_OVER: begin
              if (sts_i.cnt_lt2) begin
                status_d = ST_UNDER;
              end else if (sts_i.cnt_full) begin
                status_d = ST_OVER;
              end else begin
                cmd_o.op   = OP_PUSH;
                cmd_o.psel = PSEL_SEC;
              end
            end
            MODE_PRINT: begin
              if (sts_i.cnt_zero) begin
                status_d = ST_UNDER;
              end else begin
                cmd_o.op        = OP_POP;
                cmd_o.cap_print = 1'b1;
                state_d         = CS_FILL;
              end
            end
            MODE_SHOW: begin
              cmd_o.set_show = 1'b1;
            end
            MODE_CLEAR: begin
              cmd_o.op = OP_CLEAR;
            end
            default: begin
              // unused codes act as no-ops
            end
          endcase
        end
      end

      CS_POP: begin
        cmd_o.op     = OP_POP;
        second_pop_d = 1'b0;
        state_d      = CS_FILL;
      end

      CS_FILL: begin
        cmd_o.op = OP_FILL;
        if (second_pop_q) begin
          state_d = CS_POP;
        end else if (settop_q) begin
          state_d = CS_MDWAIT;
        end else begin
          state_d = CS_DONE;
        end
      end

      CS_MDWAIT: begin
        if (!sts_i.md_busy) begin
          cmd_o.op = OP_SETTOP;
          settop_d = 1'b0;
          state_d  = CS_DONE;
        end
      end

      CS_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.wr_out = 1'b1;
          state_d      = CS_IDLE;
        end
      end

      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/rse_dp.sv */
`default_nettype none

module rse_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire rse_pkg::cmd_t                       cmd_i,
  output rse_pkg::sts_t                            sts_o,
  input  wire logic [rse_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  input  wire logic [rse_pkg::MODE_W-1:0]          s_tuser_i,
  output logic                                     m_tvalid_o,
  input  wire logic                                m_tready_i,
  output logic [rse_pkg::OUT_TDATA_W-1:0]          m_tdata_o,
  output logic [rse_pkg::STATUS_W-1:0]             m_tuser_o
);
  import rse_pkg::*;

  logic [MODE_W-1:0] mode_q;
  word_t             lit_q;
  logic              ls_q;
  logic              skip_q;
  cnt_t              cnt_q;
  word_t             top_q, sec_q, thr_q;
  word_t             opa_q, opb_q;
  logic              pv_valid_q, show_q;
  word_t             pv_q;
  word_t             rd_q;
  word_t             mem_q [STACK_DEPTH];

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_tdata_q;
  logic [STATUS_W-1:0]    out_tuser_q;

  logic  eff_skip;
  logic  cnt_ge1, cnt_ge2, cnt_ge3;
  ptr_t  wr_ptr, rd_ptr;
  word_t push_val;
  word_t set_val;
  word_t md_result;
  logic  md_busy;
  word_t top_m, sec_m, thr_m;
  logic  is_err;

  rse_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.md_start),
    .op_i     (cmd_i.md_op),
    .a_i      (sec_q),
    .b_i      (top_q),
    .busy_o   (md_busy),
    .result_o (md_result)
  );

  always_comb begin
    eff_skip = skip_q && !ls_q;
    cnt_ge1  = (cnt_q >= CNT_W'(1));
    cnt_ge2  = (cnt_q >= CNT_W'(2));
    cnt_ge3  = (cnt_q >= CNT_W'(3));
    // entries below the top three live in the memory
    wr_ptr   = PTR_W'(cnt_q - CNT_W'(3));
    rd_ptr   = PTR_W'(cnt_q - CNT_W'(4));

    case (cmd_i.psel)
      PSEL_TOP: push_val = top_q;
      PSEL_SEC: push_val = sec_q;
      default:  push_val = lit_q;
    endcase

    if (mode_q == MODE_ADD) begin
      set_val = opa_q + opb_q;
    end else if (mode_q == MODE_SUB) begin
      set_val = opa_q - opb_q;
    end else begin
      set_val = md_result;
    end

    top_m  = cnt_ge1 ? top_q : '0;
    sec_m  = cnt_ge2 ? sec_q : '0;
    thr_m  = cnt_ge3 ? thr_q : '0;
    is_err = (cmd_i.status == ST_DIV0) || (cmd_i.status == ST_OVER) ||
             (cmd_i.status == ST_UNDER);

    sts_o.mode     = mode_e'(mode_q);
    sts_o.skip     = eff_skip;
    sts_o.cnt_zero = !cnt_ge1;
    sts_o.cnt_lt2  = !cnt_ge2;
    sts_o.cnt_full = (cnt_q == CNT_W'(STACK_DEPTH));
    sts_o.b_zero   = (top_q == '0);
    sts_o.md_busy  = md_busy;
    sts_o.out_busy = out_valid_q && !m_tready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_PUSH:  cnt_q <= cnt_q + CNT_W'(1);
        OP_POP:   cnt_q <= cnt_q - CNT_W'(1);
        OP_CLEAR: cnt_q <= '0;
        default:  cnt_q <= cnt_q;
      endcase
      if (cmd_i.wr_out) begin
        skip_q      <= eff_skip || is_err;
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q     <= s_tuser_i;
      lit_q      <= s_tdata_i[DATA_W-1:0];
      ls_q       <= s_tdata_i[DATA_W];
      pv_valid_q <= 1'b0;
      pv_q       <= '0;
      show_q     <= 1'b0;
    end
    if (cmd_i.cap_print) begin
      pv_valid_q <= 1'b1;
      pv_q       <= top_q;
    end
    if (cmd_i.set_show) begin
      show_q <= 1'b1;
    end
    if (cmd_i.latch_ops) begin
      opa_q <= sec_q;
      opb_q <= top_q;
    end

    unique case (cmd_i.op)
      OP_PUSH: begin
        top_q <= push_val;
        sec_q <= top_q;
        thr_q <= sec_q;
      end
      OP_POP: begin
        top_q <= sec_q;
        sec_q <= thr_q;
      end
      OP_FILL:   thr_q <= rd_q;
      OP_SWAP: begin
        top_q <= sec_q;
        sec_q <= top_q;
      end
      OP_SETTOP: top_q <= set_val;
      default: begin
      end
    endcase

    if (cmd_i.wr_out) begin
      out_tdata_q <= OUT_TDATA_W'({thr_m, sec_m, top_m, DEPTH_W'(cnt_q), show_q, pv_q,
                                   pv_valid_q});
      out_tuser_q <= cmd_i.status;
    end
  end

  // stack spill memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PUSH && cnt_ge3) begin
      mem_q[wr_ptr] <= thr_q;
    end
    rd_q <= mem_q[rd_ptr];
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_tdata_q;
  assign m_tuser_o  = out_tuser_q;

endmodule

`default_nettype wire

/* src/rpn_stack_evaluator_core.sv */
`default_nettype none

// RPN stack evaluator: one decoded token per input transfer, one result transfer
// per token. The top three stack words sit in registers and deeper entries spill
// into a small memory, so each token pop is followed by a refill of the third
// word. Add and sub then write the new top; mul, div and mod first wait on the
// 32-step shift-add / shift-subtract unit; divide-by-zero pops the second operand
// with a second refill. Every token ends with the write to the output register.
// A new token is accepted once the previous one has reached the output register.
module rpn_stack_evaluator_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_tvalid_i,
  output logic                                  s_tready_o,
  // literal[31:0], line_start[32], zero pad
  input  wire logic [rse_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  // mode
  input  wire logic [rse_pkg::MODE_W-1:0]       s_tuser_i,
  output logic                                  m_tvalid_o,
  input  wire logic                             m_tready_i,
  // printed_valid[0], printed_value[32:1], show_stack[33], stack_depth[38:34],
  // top_value[70:39], second_value[102:71], third_value[134:103], zero pad
  output logic [rse_pkg::OUT_TDATA_W-1:0]       m_tdata_o,
  // status
  output logic [rse_pkg::STATUS_W-1:0]          m_tuser_o
);
  import rse_pkg::*;

  localparam int unsigned PV_BIT   = 0;
  localparam int unsigned SHOW_BIT = DATA_W + 1;

  cmd_t cmd;
  sts_t sts;

  rse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rse_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("token accepted while previous one in flight");

  a_skip_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o == ST_SKIP) |-> !m_tdata_o[PV_BIT] && !m_tdata_o[SHOW_BIT])
    else $error("skipped token reported print or show");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_out |-> !sts.out_busy)
    else $error("result overwrote a pending transfer");

  a_md_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.md_start |-> !sts.md_busy)
    else $error("mul/div started while busy");

endmodule

`default_nettype wire

/* tb/sv/tb_rpn_stack_evaluator_core.sv */
module tb_rpn_stack_evaluator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rse_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned TOKEN_GOAL  = 1900;
  localparam int unsigned DRAIN_WAIT  = 60;

  typedef struct packed {
    status_e      status;
    logic         printed_valid;
    word_t        printed_value;
    logic         show_stack;
    logic [DEPTH_W-1:0] depth;
    word_t        top_value;
    word_t        second_value;
    word_t        third_value;
  } token_result_t;

  // Mirror of the evaluator: stack, depth and skip flag, plus the results still owed
  class rpn_scoreboard;
    word_t           stack_q[STACK_DEPTH];
    int unsigned     count;
    bit              skip_line;
    token_result_t   owed_q[$];
    int unsigned     errors;
    int unsigned     checked;
    int unsigned     status_hits[5];
    int unsigned     deepest;

    function new();
      count     = 0;
      skip_line = 1'b0;
      errors    = 0;
      checked   = 0;
      deepest   = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function int unsigned depth();
      return count;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function status_e push_word(word_t v);
      if (count >= STACK_DEPTH) return ST_OVER;
      stack_q[count] = v;
      count++;
      return ST_OK;
    endfunction

    function bit pop_word(output word_t v);
      v = '0;
      if (count == 0) return 1'b0;
      count--;
      v = stack_q[count];
      return 1'b1;
    endfunction

    function word_t peek(int unsigned k);
      if (k < count) return stack_q[count - 1 - k];
      return '0;
    endfunction

    // Executes one accepted token and queues the result it must produce
    function status_e note_token(logic [MODE_W-1:0] mode, word_t lit, logic line_start);
      token_result_t r;
      word_t         a, b, ma, mb, q;
      status_e       st;
      r  = '0;
      st = ST_OK;
      if (line_start) skip_line = 1'b0;
      if (skip_line) begin
        st = ST_SKIP;
      end else begin
        case (mode)
          MODE_PUSH: st = push_word(lit);
          MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD: begin
            // operands already popped stay popped when the second pop fails
            if (!pop_word(b) || !pop_word(a)) st = ST_UNDER;
            else if (mode == MODE_ADD) st = push_word(a + b);
            else if (mode == MODE_SUB) st = push_word(a - b);
            else if (mode == MODE_MUL) st = push_word(a * b);
            else if (b == '0) st = ST_DIV0;
            else begin
              ma = a[DATA_W-1] ? -a : a;
              mb = b[DATA_W-1] ? -b : b;
              if (mode == MODE_DIV) begin
                q = ma / mb;
                if (a[DATA_W-1] ^ b[DATA_W-1]) q = -q;
              end else begin
                q = ma % mb;
                if (a[DATA_W-1]) q = -q;
              end
              st = push_word(q);
            end
          end
          MODE_DUP:  st = (count == 0) ? ST_UNDER : push_word(peek(0));
          MODE_DROP: st = pop_word(a) ? ST_OK : ST_UNDER;
          MODE_SWAP: begin
            if (count < 2) st = ST_UNDER;
            else begin
              a                    = stack_q[count - 1];
              stack_q[count - 1]   = stack_q[count - 2];
              stack_q[count - 2]   = a;
            end
          end
          MODE_OVER: st = (count < 2) ? ST_UNDER : push_word(peek(1));
          MODE_PRINT: begin
            if (pop_word(a)) begin
              r.printed_valid = 1'b1;
              r.printed_value = a;
            end else begin
              st = ST_UNDER;
            end
          end
          MODE_SHOW:  r.show_stack = 1'b1;
          MODE_CLEAR: count = 0;
          default: ;
        endcase
      end
      if (st != ST_OK && st != ST_SKIP) skip_line = 1'b1;
      r.status       = st;
      r.depth        = DEPTH_W'(count);
      r.top_value    = peek(0);
      r.second_value = peek(1);
      r.third_value  = peek(2);
      owed_q.push_back(r);
      status_hits[st]++;
      if (count > deepest) deepest = count;
      return st;
    endfunction

    function void check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic [STATUS_W-1:0] tuser);
      token_result_t e;
      if (owed_q.size() == 0) begin
        $display("%0t: result transfer with nothing expected, expected none, got %h/%h",
                 $time, tuser, tdata);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      checked++;
      check_field("status",        DATA_W'(e.status),        DATA_W'(tuser));
      check_field("printed_valid", DATA_W'(e.printed_valid), DATA_W'(tdata[0]));
      check_field("printed_value", e.printed_value,          tdata[32:1]);
      check_field("show_stack",    DATA_W'(e.show_stack),    DATA_W'(tdata[33]));
      check_field("stack_depth",   DATA_W'(e.depth),         DATA_W'(tdata[38:34]));
      check_field("top_value",     e.top_value,              tdata[70:39]);
      check_field("second_value",  e.second_value,           tdata[102:71]);
      check_field("third_value",   e.third_value,            tdata[134:103]);
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_TDATA_W-1:0]    s_tdata = '0;
  logic [MODE_W-1:0]        s_tuser = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0]      m_tuser;

  rpn_scoreboard sb = new();
  bit            calm = 1'b0;
  int unsigned   tokens_sent = 0;
  int unsigned   live_tokens = 0;

  rpn_stack_evaluator_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tuser_o  (m_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_rpn_stack_evaluator_core: errors");
    $finish;
  end

  // result side: check on each transfer, stall at random
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      m_tready <= rst_n && (calm || $urandom_range(0, 99) >= 15);
    end
  end

  // valid is left high between back-to-back tokens; only an idle cycle lowers it
  task automatic send_token(input logic [MODE_W-1:0] mode, input word_t lit,
                            input logic line_start, output status_e st);
    while (!calm && $urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - DATA_W - 1){1'b0}}, line_start, lit};
    s_tuser  <= mode;
    do @(posedge clk_i); while (!(s_tvalid && s_tready));
    st = sb.note_token(mode, lit, line_start);
    tokens_sent++;
    if (st != ST_SKIP) live_tokens++;
    calm = (live_tokens >= 700 && live_tokens < 1000);
  endtask

  function automatic word_t rand_literal();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return $urandom_range(0, 1) ? 32'hffff_ffff : 32'd1;
      4, 5, 6: return word_t'($urandom_range(0, 18)) - 32'd9;
      default: return $urandom;
    endcase
  endfunction

  // well-formed line: pushes while shallow, then a mix of operators, closed by a print
  task automatic expression_line();
    int unsigned      len;
    logic [MODE_W-1:0] mode;
    status_e          st;
    len = $urandom_range(3, 14);
    if (sb.depth() > 10) send_token(MODE_CLEAR, rand_literal(), 1'b1, st);
    else send_token(MODE_PUSH, rand_literal(), 1'b1, st);
    for (int i = 0; i < len; i++) begin
      if (sb.depth() < 2 || (sb.depth() < 15 && $urandom_range(0, 99) < 35)) mode = MODE_PUSH;
      else mode = MODE_W'($urandom_range(MODE_ADD, MODE_SHOW));
      send_token(mode, rand_literal(), 1'b0, st);
    end
    send_token(MODE_PRINT, rand_literal(), 1'b0, st);
  endtask

  // grow the stack until it overflows, then a few tokens that get skipped
  task automatic fill_line();
    logic [MODE_W-1:0] mode;
    status_e          st;
    send_token(MODE_CLEAR, rand_literal(), 1'b1, st);
    send_token(MODE_PUSH, rand_literal(), 1'b0, st);
    while (st != ST_OVER) begin
      case ($urandom_range(0, 2))
        0:       mode = MODE_PUSH;
        1:       mode = MODE_DUP;
        default: mode = (sb.depth() >= 2) ? MODE_OVER : MODE_PUSH;
      endcase
      send_token(mode, rand_literal(), 1'b0, st);
    end
    repeat ($urandom_range(1, 3))
      send_token(MODE_W'($urandom_range(0, 15)), rand_literal(), 1'b0, st);
  endtask

  // shallow stack plus an operator that is likely to fail, then trailing tokens
  task automatic broken_line();
    status_e st;
    send_token(MODE_CLEAR, rand_literal(), 1'b1, st);
    repeat ($urandom_range(0, 2)) send_token(MODE_PUSH, rand_literal(), 1'b0, st);
    send_token(MODE_W'($urandom_range(MODE_ADD, MODE_PRINT)), rand_literal(), 1'b0, st);
    repeat ($urandom_range(1, 4))
      send_token(MODE_W'($urandom_range(0, 15)), rand_literal(), 1'b0, st);
  endtask

  task automatic noise_burst();
    status_e st;
    repeat ($urandom_range(1, 6))
      send_token(MODE_W'($urandom_range(0, 15)), $urandom, 1'($urandom_range(0, 1)), st);
  endtask

  initial begin : stimulus
    status_e     st;
    int unsigned pick;

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    send_token(MODE_PRINT, 32'd0,          1'b1, st);  // print on empty stack
    send_token(MODE_ADD,   32'd0,          1'b0, st);  // skipped after the error
    send_token(MODE_PUSH,  32'd5,          1'b1, st);
    send_token(MODE_SUB,   32'd0,          1'b0, st);  // one operand popped, then underflow
    send_token(MODE_PUSH,  32'd7,          1'b1, st);
    send_token(MODE_PUSH,  32'd0,          1'b0, st);
    send_token(MODE_DIV,   32'd0,          1'b0, st);  // zero divisor
    send_token(MODE_PUSH,  32'h8000_0000,  1'b1, st);
    send_token(MODE_PUSH,  32'hffff_ffff,  1'b0, st);
    send_token(MODE_DIV,   32'd0,          1'b0, st);  // minimum over minus one wraps
    send_token(MODE_PUSH,  32'hffff_ffff,  1'b0, st);
    send_token(MODE_MOD,   32'd0,          1'b0, st);
    send_token(MODE_PUSH,  32'h7fff_ffff,  1'b0, st);
    send_token(MODE_ADD,   32'd0,          1'b0, st);
    send_token(MODE_DUP,   32'hffff_ffff,  1'b0, st);
    send_token(MODE_MUL,   32'd0,          1'b0, st);
    send_token(MODE_PUSH,  32'hffff_fff9,  1'b0, st);
    send_token(MODE_PUSH,  32'd2,          1'b0, st);
    send_token(MODE_MOD,   32'd0,          1'b0, st);  // remainder takes the dividend's sign
    send_token(MODE_OVER,  32'd0,          1'b0, st);
    send_token(MODE_SWAP,  32'd0,          1'b0, st);
    send_token(MODE_DROP,  32'd0,          1'b0, st);
    send_token(MODE_SHOW,  32'd0,          1'b0, st);
    send_token(4'd13,      32'h1234_5678,  1'b0, st);  // unused code, no effect
    send_token(MODE_PRINT, 32'd0,          1'b0, st);
    send_token(MODE_CLEAR, 32'd0,          1'b0, st);
    send_token(MODE_MUL,   32'd0,          1'b0, st);  // binary op on empty stack
    send_token(MODE_PUSH,  32'd4,          1'b1, st);
    send_token(MODE_PUSH,  32'd0,          1'b0, st);
    send_token(MODE_MOD,   32'd0,          1'b0, st);

    while (live_tokens < TOKEN_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) expression_line();
      else if (pick < 75) fill_line();
      else if (pick < 88) broken_line();
      else noise_burst();
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t: results outstanding, expected 0, got %0d", $time, sb.pending());
      sb.errors++;
    end

    $display("%0d tokens driven, %0d results compared, deepest stack %0d",
             tokens_sent, sb.checked, sb.deepest);
    $display("ok %0d, zero divisor %0d, overflow %0d, underflow %0d, skipped %0d",
             sb.status_hits[ST_OK], sb.status_hits[ST_DIV0], sb.status_hits[ST_OVER],
             sb.status_hits[ST_UNDER], sb.status_hits[ST_SKIP]);
    if (sb.errors == 0) begin
      $display("tb_rpn_stack_evaluator_core: clean");
    end else begin
      $display("tb_rpn_stack_evaluator_core: errors");
    end
    $finish;
  end

endmodule
